/* rtl/core/ppc_pkg.sv */
// Package for the point projection colorizer: widths, register codes, item types.
// No dependencies.
package ppc_pkg;

    localparam int MaxWidth      = 640;
    localparam int MaxHeight     = 480;
    localparam int StoreDepth    = MaxWidth * MaxHeight;
    localparam int AddrW         = $clog2(StoreDepth);
    localparam int QuotBits      = 12;
    localparam int CoordFracBits = 16;
    localparam int SumW          = 67;
    // stages from project acceptance to the lookup register; write items trail by
    // the same count so store writes and reads keep item order
    localparam int WrDelay       = QuotBits + 4;

    localparam logic [2:0] REG_R0_AB = 3'd0;
    localparam logic [2:0] REG_R0_CD = 3'd1;
    localparam logic [2:0] REG_R1_AB = 3'd2;
    localparam logic [2:0] REG_R1_CD = 3'd3;
    localparam logic [2:0] REG_R2_AB = 3'd4;
    localparam logic [2:0] REG_R2_CD = 3'd5;
    localparam logic [2:0] REG_COLS  = 3'd6;
    localparam logic [2:0] REG_ROWS  = 3'd7;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    // Lookup request from the projector to the image store.
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [AddrW-1:0]  addr;
        point_t            pt;
    } lookup_t;

    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
    } row_coef_t;

endpackage

/* rtl/core/ppc_divider.sv */
// Pipelined restoring floor divider, one quotient bit per stage, range checked.
// Depends on ppc_pkg.
module ppc_divider
    import ppc_pkg::*;
(
    input  logic                   clk,
    input  logic                   in_valid,
    input  logic signed [SumW-1:0] num,
    input  logic signed [SumW-1:0] den,
    input  logic [QuotBits-1:0]    limit,
    output logic                   q_ok,
    output logic [QuotBits-1:0]    quot
);
    localparam int UW = SumW + QuotBits + 1;

    logic [UW-1:0]       rem_reg  [QuotBits+1];
    logic [UW-1:0]       den_reg  [QuotBits+1];
    logic [QuotBits-1:0] q_reg    [QuotBits+1];
    logic                ok_reg   [QuotBits+1];
    logic [QuotBits-1:0] lim_reg  [QuotBits+1];

    logic [SumW:0] n_abs, d_abs;
    logic          flip;

    always_comb
    begin
        flip  = den[SumW-1];
        n_abs = flip ? -{num[SumW-1], num} : {num[SumW-1], num};
        d_abs = flip ? -{den[SumW-1], den} : {den[SumW-1], den};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {{(UW-SumW-1){1'b0}}, n_abs};
        den_reg[0] <= {{(UW-SumW-1){1'b0}}, d_abs};
        q_reg[0]   <= '0;
        lim_reg[0] <= limit;
        // negative numerator or quotient too large: miss
        ok_reg[0]  <= in_valid && !n_abs[SumW] &&
                      ({{(UW-SumW-1){1'b0}}, n_abs} <
                       ({{(UW-SumW-1){1'b0}}, d_abs} << QuotBits));
    end

    for (genvar s = 0; s < QuotBits; s++)
    begin : g_stage
        localparam int B = QuotBits - 1 - s;
        logic [UW-1:0] t;
        logic          ge;
        assign t  = den_reg[s] << B;
        assign ge = rem_reg[s] >= t;
        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= ge ? rem_reg[s] - t : rem_reg[s];
            den_reg[s+1] <= den_reg[s];
            q_reg[s+1]   <= q_reg[s] | (QuotBits'(ge) << B);
            ok_reg[s+1]  <= ok_reg[s];
            lim_reg[s+1] <= lim_reg[s];
        end
    end

    assign quot = q_reg[QuotBits];
    assign q_ok = ok_reg[QuotBits] && (q_reg[QuotBits] < lim_reg[QuotBits]);
endmodule

/* rtl/core/ppc_projector.sv */
// Projection pipeline: 3x4 matrix products, floor division, bounds check, pixel address.
// Depends on ppc_pkg and ppc_divider.
module ppc_projector
    import ppc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  point_t       pt,
    input  row_coef_t    coef [3],
    input  logic [9:0]   cols,
    input  logic [8:0]   rows,
    output lookup_t      lookup
);
    localparam int Lat = QuotBits + 1;

    // stage 1: twelve products
    logic signed [63:0] prod_reg [3][4];
    logic               v1_reg;
    point_t             p1_reg;
    // stage 2: sums
    logic signed [SumW-1:0] sum_reg [3];
    logic                   v2_reg;
    point_t                 p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            prod_reg[r][0] <= coef[r].c0 * $signed(pt.x);
            prod_reg[r][1] <= coef[r].c1 * $signed(pt.y);
            prod_reg[r][2] <= coef[r].c2 * $signed(pt.z);
            prod_reg[r][3] <= 64'(coef[r].c3) <<< CoordFracBits;
            sum_reg[r] <= SumW'(prod_reg[r][0]) + SumW'(prod_reg[r][1])
                        + SumW'(prod_reg[r][2]) + SumW'(prod_reg[r][3]);
        end
        p1_reg <= pt;
        p2_reg <= p1_reg;
    end

    logic [9:0] cols_sat;
    logic [8:0] rows_sat;
    assign cols_sat = (cols > 10'(MaxWidth))  ? 10'(MaxWidth)  : cols;
    assign rows_sat = (rows > 9'(MaxHeight)) ? 9'(MaxHeight) : rows;

    logic                go;
    logic                u_ok, v_ok;
    logic [QuotBits-1:0] u_q, v_q;
    assign go = v2_reg && (sum_reg[2] != '0);

    ppc_divider u_div_u (.clk, .in_valid(go), .num(sum_reg[0]), .den(sum_reg[2]),
                         .limit(QuotBits'(cols_sat)), .q_ok(u_ok), .quot(u_q));
    ppc_divider u_div_v (.clk, .in_valid(go), .num(sum_reg[1]), .den(sum_reg[2]),
                         .limit(QuotBits'(rows_sat)), .q_ok(v_ok), .quot(v_q));

    logic   vd_reg [Lat];
    point_t pd_reg [Lat];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < Lat; i++) vd_reg[i] <= 1'b0;
        else
        begin
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < Lat; i++) vd_reg[i] <= vd_reg[i-1];
        end
    end
    always_ff @(posedge clk)
    begin
        pd_reg[0] <= p2_reg;
        for (int i = 1; i < Lat; i++) pd_reg[i] <= pd_reg[i-1];
    end

    // address stage: v*cols + u, narrow multiply
    logic [AddrW-1:0] addr_next;
    assign addr_next = AddrW'(AddrW'(v_q) * AddrW'(cols_sat)) + AddrW'(u_q);

    logic             lk_valid_reg;
    logic             lk_hit_reg;
    logic [AddrW-1:0] lk_addr_reg;
    point_t           lk_pt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lk_valid_reg <= 1'b0;
        else
            lk_valid_reg <= vd_reg[Lat-1];
    end
    always_ff @(posedge clk)
    begin
        lk_hit_reg  <= u_ok && v_ok;
        lk_addr_reg <= addr_next;
        lk_pt_reg   <= pd_reg[Lat-1];
    end

    assign lookup = '{valid: lk_valid_reg, hit: lk_hit_reg, addr: lk_addr_reg, pt: lk_pt_reg};
endmodule

/* rtl/core/ppc_image_store.sv */
// Image store: write delay line, one write port, one registered read port.
// Depends on ppc_pkg.
module ppc_image_store
    import ppc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [23:0]      wr_data,
    input  lookup_t          lookup,
    output logic             res_valid,
    output point_t           res_pt,
    output logic [23:0]      res_pix
);
    logic [23:0] mem [StoreDepth];
    logic [23:0] rd_reg;
    logic        rv_reg;
    point_t      rp_reg;

    // writes trail by the projector depth so they land in item order with reads
    logic             wv_reg [WrDelay];
    logic [AddrW-1:0] wa_reg [WrDelay];
    logic [23:0]      wd_reg [WrDelay];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < WrDelay; i++) wv_reg[i] <= 1'b0;
        else
        begin
            wv_reg[0] <= wr_en;
            for (int i = 1; i < WrDelay; i++) wv_reg[i] <= wv_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg[0] <= wr_addr;
        wd_reg[0] <= wr_data;
        for (int i = 1; i < WrDelay; i++)
        begin
            wa_reg[i] <= wa_reg[i-1];
            wd_reg[i] <= wd_reg[i-1];
        end
        if (wv_reg[WrDelay-1])
            mem[wa_reg[WrDelay-1]] <= wd_reg[WrDelay-1];
        rd_reg <= mem[lookup.addr];
        rp_reg <= lookup.pt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= lookup.valid && lookup.hit;
    end

    assign res_valid = rv_reg;
    assign res_pt    = rp_reg;
    assign res_pix   = rd_reg;
endmodule

/* rtl/core/point_projection_colorizer_core.sv */
// Top level of the point projection colorizer: config registers, flow control, output queue.
// Depends on ppc_pkg, ppc_projector, ppc_image_store.
//
//  channel | dir | handshake                 | payload
//  s_axis  | in  | s_axis_tvalid/tready      | tdata: opcode,pixel_index,c0,c1,c2,x,y,z
//  m_axis  | out | m_axis_tvalid/tready      | tdata: out_x,out_y,out_z,red,green,blue
//  apb     | cfg | psel/penable/pwrite       | paddr, pwdata, prdata
//
// One item per cycle while s_axis_tready is high. A project result passes the multiply, sum,
// 13 divider stages, address, store read and queue registers before it is offered.
// Write items pass a 16-stage delay line to the store so that store writes and project
// reads stay in item order; no result.
// Input stalls only when queued results plus projects in flight reach 32.
// Reset clears control state; the image store is not cleared.
module point_projection_colorizer_core
    import ppc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[0], pixel_index[19:1], c0[27:20], c1[35:28], c2[43:36],
    // x[75:44], y[107:76], z[139:108]
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], red[103:96], green[111:104], blue[119:112]
    output logic [119:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    localparam int QDepth = 32;

    logic [63:0] proj_reg [6];
    logic [9:0]  cols_reg;
    logic [8:0]  rows_reg;
    logic [2:0]  ridx;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign ridx   = paddr[5:3];
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++) proj_reg[i] <= '0;
            cols_reg <= 10'(MaxWidth);
            rows_reg <= 9'(MaxHeight);
        end
        else if (cfg_wr && paddr[2:0] == 3'd0)
        begin
            case (ridx)
                REG_COLS: cols_reg <= pwdata[9:0];
                REG_ROWS: rows_reg <= pwdata[8:0];
                default:  proj_reg[ridx] <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_COLS: prdata = {54'd0, cols_reg};
            REG_ROWS: prdata = {55'd0, rows_reg};
            default:  prdata = proj_reg[ridx];
        endcase
    end

    row_coef_t coef [3];
    always_comb
        for (int r = 0; r < 3; r++)
        begin
            coef[r].c0 = proj_reg[2*r][31:0];
            coef[r].c1 = proj_reg[2*r][63:32];
            coef[r].c2 = proj_reg[2*r+1][31:0];
            coef[r].c3 = proj_reg[2*r+1][63:32];
        end

    // input decode
    logic       acc;
    logic       op;
    logic [18:0] pidx;
    point_t     pt;
    assign op   = s_axis_tdata[0];
    assign pidx = s_axis_tdata[19:1];
    assign pt.x = s_axis_tdata[75:44];
    assign pt.y = s_axis_tdata[107:76];
    assign pt.z = s_axis_tdata[139:108];

    // credit count: queue entries plus projects in flight
    logic [5:0] credit_reg, credit_next;
    assign s_axis_tready = credit_reg < 6'(QDepth);
    assign acc = s_axis_tvalid && s_axis_tready;

    lookup_t     lookup;
    logic        res_valid;
    point_t      res_pt;
    logic [23:0] res_pix;

    ppc_projector u_proj (.clk, .rst_n, .in_valid(acc && op == OP_PROJECT), .pt,
                          .coef, .cols(cols_reg), .rows(rows_reg), .lookup);

    ppc_image_store u_store (.clk, .rst_n,
        .wr_en(acc && op == OP_WRITE && pidx < 19'(StoreDepth)),
        .wr_addr(AddrW'(pidx)), .wr_data(s_axis_tdata[43:20]),
        .lookup, .res_valid, .res_pt, .res_pix);

    // result queue
    logic [119:0] q_mem [QDepth];
    logic [4:0]   wp_reg, rp_reg;
    logic [5:0]   cnt_reg;
    logic         pop, miss;
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign miss = lookup.valid && !lookup.hit;
    assign m_axis_tvalid = cnt_reg != '0;
    assign m_axis_tdata  = q_mem[rp_reg];

    always_ff @(posedge clk)
        if (res_valid)
            q_mem[wp_reg] <= {res_pix[23:16], res_pix[15:8], res_pix[7:0],
                              res_pt.z, res_pt.y, res_pt.x};

    always_comb
        credit_next = credit_reg + 6'(acc && op == OP_PROJECT) - 6'(pop) - 6'(miss);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (res_valid) wp_reg <= wp_reg + 5'd1;
            if (pop) rp_reg <= rp_reg + 5'd1;
            cnt_reg <= cnt_reg + 6'(res_valid) - 6'(pop);
            credit_reg <= credit_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= credit_reg)
        else $error("queue holds more than its credits");
    assert property (@(posedge clk) disable iff (!rst_n) !(res_valid && cnt_reg == 6'(QDepth)))
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) credit_reg <= 6'(QDepth))
        else $error("credit count out of range");
endmodule

/* verif/point_projection_colorizer_core_tb.sv */
// Self-checking testbench for point_projection_colorizer_core: pixel writes and point projections
// over streaming ports, predicted results compared item by item. Depends on ppc_pkg and the RTL.
`timescale 1ns / 100ps

module point_projection_colorizer_core_tb
    import ppc_pkg::*;
();

    typedef struct {
        bit        op;
        bit [18:0] idx;
        bit [7:0]  c0, c1, c2;
        bit [31:0] x, y, z;
    } req_t;

    typedef struct packed {
        bit [31:0] x, y, z;
        bit [7:0]  red, green, blue;
    } color_pt_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         psel, penable, pwrite, pready;
    logic [5:0]   paddr;
    logic [63:0]  pwdata, prdata;

    point_projection_colorizer_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    bit [63:0]  proj_coef [6];
    bit [9:0]   cols_cfg;
    bit [8:0]   rows_cfg;
    bit [23:0]  pixel_mem [StoreDepth];
    bit         pixel_seen [StoreDepth];   // written so far by the generator

    req_t       pending_items [$];
    color_pt_t  colored_pts [$];
    req_t       cur_item;
    bit         in_fire;
    int         in_gap, out_stall;
    bit         in_burst, out_burst;
    int         mismatches;
    int         cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Pixel store address hit by a point, if any, under the current settings.
    function automatic bit locate(input bit [31:0] px, py, pz, output int unsigned at);
        logic signed [127:0] s [3];
        logic signed [127:0] den, n0, n1, q0, q1;
        longint k0, k1, k2, k3;
        int unsigned cw, rh;
        at = 0;
        for (int r = 0; r < 3; r++)
        begin
            k0 = longint'(signed'(proj_coef[2*r][31:0]));
            k1 = longint'(signed'(proj_coef[2*r][63:32]));
            k2 = longint'(signed'(proj_coef[2*r+1][31:0]));
            k3 = longint'(signed'(proj_coef[2*r+1][63:32]));
            s[r] = 0;
            s[r] = s[r] + k0 * longint'(signed'(px));
            s[r] = s[r] + k1 * longint'(signed'(py));
            s[r] = s[r] + k2 * longint'(signed'(pz));
            s[r] = s[r] + k3 * (longint'(1) << CoordFracBits);
        end
        if (s[2] == 0)
            return 0;
        den = s[2];
        n0  = s[0];
        n1  = s[1];
        if (den < 0)
        begin
            den = -den;
            n0  = -n0;
            n1  = -n1;
        end
        cw = (cols_cfg > MaxWidth) ? MaxWidth : cols_cfg;
        rh = (rows_cfg > MaxHeight) ? MaxHeight : rows_cfg;
        if (n0 < 0 || n1 < 0)
            return 0;
        q0 = n0 / den;
        q1 = n1 / den;
        if (q0 >= cw || q1 >= rh)
            return 0;
        at = int'(q1) * cw + int'(q0);
        return 1;
    endfunction

    task automatic apb_write(input logic [2:0] code, input bit [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {code, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (code)
            REG_COLS: cols_cfg = val[9:0];
            REG_ROWS: rows_cfg = val[8:0];
            default:  proj_coef[code] = val;
        endcase
    endtask

    task automatic setup(input bit [31:0] c [12], input bit [9:0] cw, input bit [8:0] rh);
        logic [2:0] regs [6];
        regs = '{REG_R0_AB, REG_R0_CD, REG_R1_AB, REG_R1_CD, REG_R2_AB, REG_R2_CD};
        for (int i = 0; i < 6; i++)
            apb_write(regs[i], {c[2*i+1], c[2*i]});
        apb_write(REG_COLS, 64'(cw));
        apb_write(REG_ROWS, 64'(rh));
        in_burst  = ($urandom_range(0, 2) == 0);
        out_burst = ($urandom_range(0, 2) == 0);
    endtask

    task automatic put_pixel(input bit [18:0] idx);
        req_t it;
        it.op  = OP_WRITE;
        it.idx = idx;
        it.c0  = 8'($urandom);
        it.c1  = 8'($urandom);
        it.c2  = 8'($urandom);
        it.x   = $urandom;
        it.y   = $urandom;
        it.z   = $urandom;
        pending_items = {pending_items, it};
        if (idx < StoreDepth)
            pixel_seen[idx] = 1'b1;
    endtask

    // Any pixel the point would read gets written first.
    task automatic put_point(input bit [31:0] px, py, pz);
        req_t it;
        int unsigned at;
        if (locate(px, py, pz, at) && !pixel_seen[at])
            put_pixel(19'(at));
        it.op  = OP_PROJECT;
        it.idx = 19'($urandom);
        it.c0  = 8'($urandom);
        it.c1  = 8'($urandom);
        it.c2  = 8'($urandom);
        it.x   = px;
        it.y   = py;
        it.z   = pz;
        pending_items = {pending_items, it};
    endtask

    function automatic int pick_cell(input int unsigned lim);
        int unsigned e;
        e = (lim > 0) ? lim : 1;
        return int'($urandom_range(0, e + 1)) - int'($urandom_range(0, 1));
    endfunction

    // Random stream: writes, well-formed projections, raw points.
    // persp: 0 means s2 is constant 2^32, else d = persp * z divides.
    task automatic random_mix(input int n, input int persp);
        int u, v, d, kind;
        int unsigned cw, rh;
        cw = (cols_cfg > MaxWidth) ? MaxWidth : cols_cfg;
        rh = (rows_cfg > MaxHeight) ? MaxHeight : rows_cfg;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 19);
            u = pick_cell(cw);
            v = pick_cell(rh);
            if (kind < 4)
                put_pixel(19'($urandom));
            else if (kind < 6)
                put_pixel(19'(($urandom_range(0, rh) * cw + $urandom_range(0, cw)) % StoreDepth));
            else if (kind < 8)
                put_point($urandom, $urandom, $urandom);
            else if (persp == 0)
                put_point(u * 65536 + $urandom_range(0, 65535),
                          v * 65536 + $urandom_range(0, 65535), $urandom);
            else
            begin
                d = $urandom_range(1, 1 << 20);
                if ($urandom_range(0, 1))
                    d = -d;
                put_point(u * d + (d > 0 ? $urandom_range(0, d - 1) : -$urandom_range(0, -d - 1)),
                          v * d + (d > 0 ? $urandom_range(0, d - 1) : -$urandom_range(0, -d - 1)),
                          persp * d);
            end
        end
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !s_axis_tvalid && colored_pts.size() == 0);
        repeat (30) @(negedge clk);
    endtask

    // input side and output ready: stimulus at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !in_fire))
        begin
            if (in_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                in_gap--;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                s_axis_tdata <= {4'b0, cur_item.z, cur_item.y, cur_item.x, cur_item.c2,
                                 cur_item.c1, cur_item.c0, cur_item.idx, cur_item.op};
                s_axis_tvalid <= 1'b1;
                in_gap = in_burst ? 0 : $urandom_range(0, 5);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        if (rst_n)
        begin
            if (out_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                out_stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // accept, predict and check at the rising edge
    always @(posedge clk)
    begin
        color_pt_t got, want;
        int unsigned at;
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire)
        begin
            if (cur_item.op == OP_WRITE)
            begin
                if (cur_item.idx < StoreDepth)
                    pixel_mem[cur_item.idx] = {cur_item.c2, cur_item.c1, cur_item.c0};
            end
            else if (locate(cur_item.x, cur_item.y, cur_item.z, at))
            begin
                want.x     = cur_item.x;
                want.y     = cur_item.y;
                want.z     = cur_item.z;
                want.red   = pixel_mem[at][7:0];
                want.green = pixel_mem[at][15:8];
                want.blue  = pixel_mem[at][23:16];
                colored_pts = {colored_pts, want};
            end
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.x     = m_axis_tdata[31:0];
            got.y     = m_axis_tdata[63:32];
            got.z     = m_axis_tdata[95:64];
            got.red   = m_axis_tdata[103:96];
            got.green = m_axis_tdata[111:104];
            got.blue  = m_axis_tdata[119:112];
            if (colored_pts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: x=%h y=%h z=%h rgb=%h %h %h",
                             got.x, got.y, got.z, got.red, got.green, got.blue);
            end
            else
            begin
                want = colored_pts.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%h y=%h z=%h rgb=%h %h %h,",
                                  " got x=%h y=%h z=%h rgb=%h %h %h"},
                                 want.x, want.y, want.z, want.red, want.green, want.blue,
                                 got.x, got.y, got.z, got.red, got.green, got.blue);
                end
            end
            out_stall = out_burst ? 0 : $urandom_range(0, 5);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 300000)
        begin
            $display("point_projection_colorizer_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        bit [31:0] c [12];
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        proj_coef     = '{default: 0};
        cols_cfg      = 10'd640;
        rows_cfg      = 9'd480;
        in_gap        = 0;
        out_stall     = 0;
        in_fire       = 0;
        mismatches    = 0;
        cycles        = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero matrix, depth sum always zero
        put_pixel(19'd0);
        put_pixel(19'd307199);
        put_pixel(19'd307200);
        put_pixel(19'h7FFFF);
        put_point(32'h7FFFFFFF, 32'h80000000, 32'h00010000);
        put_point(32'h0, 32'h0, 32'h0);
        drain();

        // identity: column and row are the integer parts of x and y
        c = '{default: 0};
        c[0] = 32'h10000;
        c[5] = 32'h10000;
        c[11] = 32'h10000;
        setup(c, 10'd640, 9'd480);
        put_point(32'h0, 32'h0, 32'h0);
        put_point(639 * 65536 + 65535, 479 * 65536 + 65535, 32'hFFFFFFFF);
        put_point(640 * 65536, 0, 0);
        put_point(0, 480 * 65536, 0);
        put_point(32'hFFFFFFFF, 0, 0);
        put_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        put_point(32'h80000000, 32'h80000000, 32'h80000000);
        random_mix(135, 0);
        drain();

        // perspective with oversized image settings (saturate), zero depth
        c = '{default: 0};
        c[0] = 32'h10000;
        c[5] = 32'h10000;
        c[10] = 32'h10000;
        setup(c, 10'h3FF, 9'h1FF);
        put_point(32'h10000, 32'h10000, 32'h0);
        put_point(-32'sd10, -32'sd10, -32'sd1);
        random_mix(135, 1);
        drain();

        // negated depth row
        c[10] = 32'hFFFF0000;
        setup(c, 10'd320, 9'd200);
        random_mix(120, -1);
        drain();

        // one-pixel image
        c = '{default: 0};
        c[0] = 32'h10000;
        c[5] = 32'h10000;
        c[11] = 32'h10000;
        setup(c, 10'd1, 9'd1);
        random_mix(40, 0);
        drain();

        // zero width or zero height: nothing hits
        setup(c, 10'd0, 9'($urandom_range(1, 480)));
        random_mix(30, 0);
        drain();
        setup(c, 10'd7, 9'd0);
        random_mix(15, 0);
        drain();

        // random matrices, extreme coefficients included
        for (int i = 0; i < 12; i++)
            c[i] = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000)
                                               : $urandom;
        setup(c, 10'($urandom_range(1, 640)), 9'($urandom_range(1, 480)));
        random_mix(45, 0);
        drain();

        c = '{default: 0};
        c[0] = 32'h10000;
        c[5] = 32'h10000;
        c[10] = 32'h10000;
        setup(c, 10'($urandom_range(1, 640)), 9'($urandom_range(1, 480)));
        random_mix(120, 1);
        drain();

        if (mismatches == 0)
            $display("point_projection_colorizer_core regression: pass");
        else
            $display("point_projection_colorizer_core regression: fail");
        $finish;
    end

endmodule
